/* sv/fps_pkg.sv */
// fps_pkg: shared types, constants and the control store of the prefix-sum table.
// Used by fps_useq, fps_dpath and the top level fenwick_prefix_sum_table.
// No dependencies.
`default_nettype none

package fps_pkg;

    // Fixed field widths and the default table depth
    localparam int POS_W       = 11;
    localparam int DATA_W      = 32;
    localparam int ENTRIES_DEF = 1024;

    // Microprogram step addresses
    typedef enum logic [2:0] {
        S_CLEAR    = 3'd0,
        S_IDLE     = 3'd1,
        S_DECODE   = 3'd2,
        S_UPD_CHK  = 3'd3,
        S_UPD_LOOP = 3'd4,
        S_QRY_CHK  = 3'd5,
        S_QRY_LOOP = 3'd6,
        S_EMIT     = 3'd7
    } t_upc;

    // Datapath action per step
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_CLEAR,
        ACT_LOAD,
        ACT_DECODE,
        ACT_UPD,
        ACT_QACC,
        ACT_EMIT
    } t_act;

    // Jump condition per step
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_START,
        C_CLR_DONE,
        C_QUERY,
        C_UPD_SKIP,
        C_UP_DONE,
        C_POS_ZERO,
        C_DN_DONE
    } t_cond;

    // Read address source
    typedef enum logic [1:0] {
        RS_CUR,
        RS_UP,
        RS_DN
    } t_rsel;

    // One control word
    typedef struct packed {
        logic  busy;
        t_act  act;
        t_cond cond;
        logic  stay;
        t_upc  target;
        t_rsel rsel;
    } t_ctrl;

    // Status from datapath to sequencer
    typedef struct packed {
        logic start;
        logic clr_done;
        logic is_query;
        logic upd_skip;
        logic up_done;
        logic pos_zero;
        logic dn_done;
    } t_flags;

    // Control store: one word per step
    function automatic t_ctrl ucode(input t_upc upc);
        t_ctrl w;
        w = '{busy: 1'b1, act: ACT_NONE, cond: C_NEVER, stay: 1'b0,
              target: S_IDLE, rsel: RS_CUR};
        case (upc)
            S_CLEAR: begin
                w.act    = ACT_CLEAR;
                w.cond   = C_CLR_DONE;
                w.stay   = 1'b1;
                w.target = S_IDLE;
            end
            S_IDLE: begin
                w.busy   = 1'b0;
                w.act    = ACT_LOAD;
                w.cond   = C_START;
                w.stay   = 1'b1;
                w.target = S_DECODE;
            end
            S_DECODE: begin
                w.act    = ACT_DECODE;
                w.cond   = C_QUERY;
                w.target = S_QRY_CHK;
            end
            S_UPD_CHK: begin
                w.cond   = C_UPD_SKIP;
                w.target = S_IDLE;
                w.rsel   = RS_CUR;
            end
            S_UPD_LOOP: begin
                w.act    = ACT_UPD;
                w.cond   = C_UP_DONE;
                w.stay   = 1'b1;
                w.target = S_IDLE;
                w.rsel   = RS_UP;
            end
            S_QRY_CHK: begin
                w.cond   = C_POS_ZERO;
                w.target = S_EMIT;
                w.rsel   = RS_CUR;
            end
            S_QRY_LOOP: begin
                w.act    = ACT_QACC;
                w.cond   = C_DN_DONE;
                w.stay   = 1'b1;
                w.target = S_EMIT;
                w.rsel   = RS_DN;
            end
            S_EMIT: begin
                w.act    = ACT_EMIT;
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* sv/fps_ram.sv */
// fps_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module fps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* sv/fps_useq.sv */
// fps_useq: step counter and control store lookup with conditional jumps.
// Depends on fps_pkg.
`default_nettype none

module fps_useq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire fps_pkg::t_flags i_flags,
    output fps_pkg::t_ctrl       o_ctrl
);

    fps_pkg::t_upc  r_upc;
    fps_pkg::t_upc  n_upc;
    fps_pkg::t_ctrl w_ctrl;
    logic           w_take;

    assign w_ctrl = fps_pkg::ucode(r_upc);
    assign o_ctrl = w_ctrl;

    // Condition select
    always_comb begin
        case (w_ctrl.cond)
            fps_pkg::C_NEVER:    w_take = 1'b0;
            fps_pkg::C_ALWAYS:   w_take = 1'b1;
            fps_pkg::C_START:    w_take = i_flags.start;
            fps_pkg::C_CLR_DONE: w_take = i_flags.clr_done;
            fps_pkg::C_QUERY:    w_take = i_flags.is_query;
            fps_pkg::C_UPD_SKIP: w_take = i_flags.upd_skip;
            fps_pkg::C_UP_DONE:  w_take = i_flags.up_done;
            fps_pkg::C_POS_ZERO: w_take = i_flags.pos_zero;
            fps_pkg::C_DN_DONE:  w_take = i_flags.dn_done;
            default:             w_take = 1'b1;
        endcase
    end

    // Next step: jump, hold, or fall through
    always_comb begin
        if (w_take) begin
            n_upc = w_ctrl.target;
        end else if (w_ctrl.stay) begin
            n_upc = r_upc;
        end else begin
            n_upc = fps_pkg::t_upc'(r_upc + 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= fps_pkg::S_CLEAR;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

`default_nettype wire

/* sv/fps_dpath.sv */
// fps_dpath: position walker, accumulator, clear counter and RAM port drive.
// Depends on fps_pkg; drives an fps_ram instance from the top level.
`default_nettype none

module fps_dpath #(
    parameter int ENTRIES = fps_pkg::ENTRIES_DEF,
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire fps_pkg::t_ctrl             i_ctrl,
    input  wire logic                       i_start,
    input  wire logic                       i_op,
    input  wire logic [fps_pkg::POS_W-1:0]  i_position,
    input  wire logic [fps_pkg::DATA_W-1:0] i_amount,
    input  wire logic [fps_pkg::DATA_W-1:0] i_rdata,
    output fps_pkg::t_flags                 o_flags,
    output logic                            o_we,
    output logic      [AW-1:0]              o_waddr,
    output logic      [fps_pkg::DATA_W-1:0] o_wdata,
    output logic      [AW-1:0]              o_raddr,
    output logic                            o_valid,
    output logic      [fps_pkg::DATA_W-1:0] o_total
);

    // Walk register holds positions up to twice the table size
    localparam int PW = (AW + 2 > fps_pkg::POS_W + 1) ? AW + 2 : fps_pkg::POS_W + 1;
    localparam logic [PW-1:0] ENT_P  = PW'(ENTRIES);
    localparam logic [AW-1:0] LAST_A = AW'(ENTRIES - 1);

    logic [PW-1:0]             r_pos;
    logic                      r_op;
    logic [fps_pkg::DATA_W-1:0] r_amt;
    logic [fps_pkg::DATA_W-1:0] r_acc;
    logic [AW-1:0]             r_clr;
    logic                      r_valid;
    logic [fps_pkg::DATA_W-1:0] r_total;

    logic [PW-1:0] w_lsb;
    logic [PW-1:0] w_up;
    logic [PW-1:0] w_dn;
    logic [PW-1:0] w_rpos;
    logic [PW-1:0] w_ridx;

    function automatic logic [AW-1:0] w_ridx_cur();
        logic [PW-1:0] idx;
        idx = r_pos - PW'(1);
        return idx[AW-1:0];
    endfunction

    // Lowest set bit, next upward and downward positions
    assign w_lsb = r_pos & (~r_pos + PW'(1));
    assign w_up  = r_pos + w_lsb;
    assign w_dn  = r_pos & (r_pos - PW'(1));

    // Read address select
    always_comb begin
        case (i_ctrl.rsel)
            fps_pkg::RS_CUR: w_rpos = r_pos;
            fps_pkg::RS_UP:  w_rpos = w_up;
            fps_pkg::RS_DN:  w_rpos = w_dn;
            default:         w_rpos = r_pos;
        endcase
    end
    assign w_ridx  = w_rpos - PW'(1);
    assign o_raddr = w_ridx[AW-1:0];

    // Write port: clearing sweep or update of the current node
    assign o_we    = (i_ctrl.act == fps_pkg::ACT_CLEAR) || (i_ctrl.act == fps_pkg::ACT_UPD);
    assign o_waddr = (i_ctrl.act == fps_pkg::ACT_CLEAR) ? r_clr : w_ridx_cur();
    assign o_wdata = (i_ctrl.act == fps_pkg::ACT_CLEAR) ? '0 : i_rdata + r_amt;

    // Status for the sequencer
    assign o_flags.start    = i_start;
    assign o_flags.clr_done = (r_clr == LAST_A);
    assign o_flags.is_query = r_op;
    assign o_flags.upd_skip = (r_pos == '0) || (r_pos > ENT_P);
    assign o_flags.up_done  = (w_up > ENT_P);
    assign o_flags.pos_zero = (r_pos == '0);
    assign o_flags.dn_done  = (w_dn == '0);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_ctrl.act == fps_pkg::ACT_EMIT);
            if (i_ctrl.act == fps_pkg::ACT_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        case (i_ctrl.act)
            fps_pkg::ACT_LOAD: begin
                r_op  <= i_op;
                r_pos <= {{(PW - fps_pkg::POS_W){1'b0}}, i_position};
                r_amt <= i_amount;
            end
            fps_pkg::ACT_DECODE: begin
                r_acc <= '0;
                // queries past the end cover the whole table
                if (r_op && (r_pos > ENT_P)) begin
                    r_pos <= ENT_P;
                end
            end
            fps_pkg::ACT_UPD: begin
                r_pos <= w_up;
            end
            fps_pkg::ACT_QACC: begin
                r_acc <= r_acc + i_rdata;
                r_pos <= w_dn;
            end
            fps_pkg::ACT_EMIT: begin
                r_total <= r_acc;
            end
            default: begin
            end
        endcase
    end

    assign o_valid = r_valid;
    assign o_total = r_total;

endmodule

`default_nettype wire

/* sv/fenwick_prefix_sum_table.sv */
// fenwick_prefix_sum_table: binary indexed tree of wrapping 32-bit sums.
// Update: busy from the request until the upward walk of at most log2(ENTRIES)+1 nodes ends.
// Query: busy while the downward walk accumulates its nodes, then the result strobe follows;
// one node per cycle, set by the single RAM read port of the node store.
// Reset: a clearing sweep writes zero to all ENTRIES words, busy high for the whole sweep
// after reset is released. Results are presented for one cycle on o_valid; no stall.
`default_nettype none

module fenwick_prefix_sum_table #(
    parameter int ENTRIES = fps_pkg::ENTRIES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       i_op,
    input  wire logic [fps_pkg::POS_W-1:0]  i_position,
    input  wire logic [fps_pkg::DATA_W-1:0] i_amount,
    output logic                            o_valid,
    output logic      [fps_pkg::DATA_W-1:0] o_prefix_total
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    fps_pkg::t_ctrl             w_ctrl;
    fps_pkg::t_flags            w_flags;
    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic [fps_pkg::DATA_W-1:0] w_wdata;
    logic [AW-1:0]              w_raddr;
    logic [fps_pkg::DATA_W-1:0] w_rdata;

    // Sequencer
    fps_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    // Datapath
    fps_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_start    (start),
        .i_op       (i_op),
        .i_position (i_position),
        .i_amount   (i_amount),
        .i_rdata    (w_rdata),
        .o_flags    (w_flags),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_raddr    (w_raddr),
        .o_valid    (o_valid),
        .o_total    (o_prefix_total)
    );

    // Node store
    fps_ram #(
        .WIDTH (fps_pkg::DATA_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign busy = w_ctrl.busy;

`ifndef NO_ASSERTIONS
    // An accepted request keeps the block busy on the next cycle
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // A result strobe follows a busy cycle
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a query in flight");

    // At most one strobe per query
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe repeated");

    // The node store is only written while busy
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> busy)
        else $error("node store written while idle");
`endif

endmodule

`default_nettype wire
